@@ rtl/core/bdq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared codes, defaults and controller/datapath bundles for the bounded
// deque with delete.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FUNC_W         = 3;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_POP_BACK   = 3'd1,
    FN_PUSH_FRONT = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_DELETE     = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;     // item accepted: latch word, read front/back, arm walk
    logic    rd_back;     // capture read targets the back entry
    logic    push_back;
    logic    push_front;
    logic    pop_back;
    logic    pop_front;
    logic    scan_step;   // read next ring slot of the walk
    logic    shift_wr;    // move fetched entry one slot toward the front
    logic    del_dec;     // delete finished: drop one entry
    logic    res_load;    // load result registers
    logic    res_pop;     // result carries the fetched word
    status_t res_code;
  } bdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic match;          // fetched entry equals the delete word
    logic last;           // fetched entry is the back entry
  } bdq_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/bounded_deque_with_delete.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_with_delete
// Double-ended queue of up to DEPTH signed words in a ring, with push and pop
// at both ends and delete of the first matching word.
// ----------------------------------------------------------------------------
//
//  channel   handshake          fields                       notes
//  --------  -----------------  ---------------------------  ------------------
//  command   start / busy       func[2:0], value[31:0]       taken: start & !busy
//  result    done (1 cycle)     popped[31:0], status[1:0],   one result per item
//                               occupancy
//
//  Push, pop, unused codes and a delete of an empty queue go from acceptance
//  straight to the result (accept, result). Any other delete walks the ring
//  once through its read port and write port, comparing up to the hit and
//  then moving each later entry one slot toward the front.
//  busy is high from the cycle after acceptance through the done cycle.
//  Reset (rst, synchronous): empty queue, head at slot 0; ring contents are
//  not cleared and are never read before being written.
//  The result receiver cannot stall: done marks the only cycle a result shows.
//
module bounded_deque_with_delete #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [bdq_pkg::FUNC_W-1:0]         func,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0] value,
  output logic                                    done,
  output logic signed [bdq_pkg::VALUE_W-1:0]      popped,
  output logic [bdq_pkg::STATUS_W-1:0]            status,
  output logic [$clog2(DEPTH+1)-1:0]              occupancy
);
  import bdq_pkg::*;

  bdq_cmd_t  cmd;   // sequencer commands
  bdq_stat_t stat;  // empty/full and walk flags

  // Sequencer: decides each item from func and the empty/full flags, then
  // steps the delete walk until the back entry has been visited.
  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: ring memory with registered read, head and count, and the
  // registered result (popped word is zero unless a pop succeeded).
  bdq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .stat      (stat),
    .popped    (popped),
    .status    (status),
    .occupancy (occupancy)
  );

endmodule
`default_nettype wire

@@ rtl/core/bdq_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dp
// Ring storage, head pointer, fill count, walk pointers and result registers.
// ----------------------------------------------------------------------------
module bdq_dp #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bdq_pkg::bdq_cmd_t                  cmd,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0] value,
  output bdq_pkg::bdq_stat_t                      stat,
  output logic signed [bdq_pkg::VALUE_W-1:0]      popped,
  output logic [bdq_pkg::STATUS_W-1:0]            status,
  output logic [CW-1:0]                           occupancy
);
  import bdq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] word_in;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] wdata;

  logic [PW-1:0] head;
  logic [CW-1:0] count;
  logic [PW-1:0] rd_pos;     // slot the walk reads next
  logic [PW-1:0] data_pos;   // slot held in rdata
  logic [PW-1:0] prev_pos;   // slot one before data_pos (equal to it at capture)
  logic [CW-1:0] data_off;   // offset of rdata from the front

  logic [PW-1:0] head_dec;
  logic [PW-1:0] back_pos;
  logic [PW-1:0] tail_pos;
  logic [PW-1:0] raddr;
  logic [PW-1:0] waddr;
  logic          re;
  logic          we;

  status_t status_q;
  logic    pop_ok;

  // base + off modulo DEPTH; exact for base below DEPTH and off up to DEPTH
  function automatic logic [PW-1:0] pos_add(input logic [PW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[PW-1:0];
  endfunction

  assign word_in  = DATA_WIDTH'(value);
  assign head_dec = (head == '0) ? PW'(DEPTH - 1) : head - 1'b1;
  assign back_pos = pos_add(head, count - 1'b1);
  assign tail_pos = pos_add(head, count);

  assign re    = cmd.capture | cmd.scan_step;
  assign raddr = cmd.capture ? (cmd.rd_back ? back_pos : head) : rd_pos;
  assign we    = cmd.push_back | cmd.push_front | cmd.shift_wr;
  assign waddr = cmd.shift_wr ? prev_pos : (cmd.push_front ? head_dec : tail_pos);
  assign wdata = cmd.shift_wr ? rdata : word_in;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // walk pointers and delete word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word     <= word_in;
      rd_pos   <= pos_add(head, CW'(1));
      data_pos <= head;
      prev_pos <= head;
      data_off <= '0;
    end else if (cmd.scan_step) begin
      rd_pos   <= pos_add(rd_pos, CW'(1));
      data_pos <= rd_pos;
      prev_pos <= data_pos;
      data_off <= data_off + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      status_q <= ST_OK;
      pop_ok   <= 1'b0;
    end else begin
      if (cmd.push_back) begin
        count <= count + 1'b1;
      end
      if (cmd.push_front) begin
        head  <= head_dec;
        count <= count + 1'b1;
      end
      if (cmd.pop_back || cmd.del_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.pop_front) begin
        head  <= pos_add(head, CW'(1));
        count <= count - 1'b1;
      end
      if (cmd.res_load) begin
        status_q <= cmd.res_code;
        pop_ok   <= cmd.res_pop;
      end
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.match = (rdata == word);
  assign stat.last  = ((CW+1)'(data_off) + 1'b1) == (CW+1)'(count);

  assign popped    = pop_ok ? VALUE_W'($signed(rdata)) : '0;
  assign status    = status_q;
  assign occupancy = count;

  // storage never overfills and the ring pointer stays in range
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_head_range : assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(head) < (CW+1)'(DEPTH))
    else $error("head pointer out of ring");

  // one item moves the count by one at most
  a_count_step : assert property (@(posedge clk) disable iff (rst)
    $past(rst) || (count == $past(count)) || (count == $past(count) + 1'b1) ||
    (count + 1'b1 == $past(count)))
    else $error("fill count jumped");

  // a gap move never collides with a push on the single write port
  a_one_writer : assert property (@(posedge clk) disable iff (rst)
    !(cmd.shift_wr && (cmd.push_back || cmd.push_front || cmd.capture)))
    else $error("shift write overlaps a push");

endmodule
`default_nettype wire

@@ rtl/core/bdq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: decodes an accepted item, runs the delete walk, strobes result.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bdq_pkg::FUNC_W-1:0]  func,
  input  wire bdq_pkg::bdq_stat_t          stat,
  output bdq_pkg::bdq_cmd_t                cmd,
  output logic                             busy,
  output logic                             done
);
  import bdq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_code = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture  = 1'b1;
          cmd.rd_back  = (func == FN_POP_BACK);
          cmd.res_load = 1'b1;
          state_next   = S_RESP;
          case (func)
            FN_PUSH_BACK: begin
              if (stat.full) cmd.res_code = ST_FULL;
              else           cmd.push_back = 1'b1;
            end
            FN_PUSH_FRONT: begin
              if (stat.full) cmd.res_code = ST_FULL;
              else           cmd.push_front = 1'b1;
            end
            FN_POP_BACK: begin
              if (stat.empty) begin
                cmd.res_code = ST_EMPTY;
              end else begin
                cmd.pop_back = 1'b1;
                cmd.res_pop  = 1'b1;
              end
            end
            FN_POP_FRONT: begin
              if (stat.empty) begin
                cmd.res_code = ST_EMPTY;
              end else begin
                cmd.pop_front = 1'b1;
                cmd.res_pop   = 1'b1;
              end
            end
            FN_DELETE: begin
              if (stat.empty) begin
                cmd.res_code = ST_NOMATCH;
              end else begin
                cmd.res_load = 1'b0;
                state_next   = S_SCAN;
              end
            end
            default: ;  // unused codes: no-op, ok
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.match) begin
          if (stat.last) begin
            cmd.del_dec  = 1'b1;
            cmd.res_load = 1'b1;
            state_next   = S_RESP;
          end else begin
            state_next = S_SHIFT;
          end
        end else if (stat.last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_NOMATCH;
          state_next   = S_RESP;
        end
      end
      S_SHIFT: begin
        cmd.scan_step = 1'b1;
        cmd.shift_wr  = 1'b1;
        if (stat.last) begin
          cmd.del_dec  = 1'b1;
          cmd.res_load = 1'b1;
          state_next   = S_RESP;
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

  // strobe lasts a single cycle
  a_done_pulse : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  // anything but a delete answers in the cycle after acceptance
  a_simple_resp : assert property (@(posedge clk) disable iff (rst)
    (accept && (func != FN_DELETE)) |=> done)
    else $error("simple item did not answer");

  // the gap walk only follows a hit
  a_shift_entry : assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> ($past(state) == S_SHIFT) ||
                           ($past(state) == S_SCAN && $past(stat.match)))
    else $error("shift without match");

endmodule
`default_nettype wire
